// ===== src/assert_macros.svh =====
// Assertion macros used by the rational arithmetic unit RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define RAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define RAU_ASSERT_IMP(lbl, ante, cons, msg) \
  `RAU_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define RAU_ASSERT_NXT(lbl, ante, cons, msg) \
  `RAU_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== src/rau_pkg.sv =====
// Package for the rational arithmetic unit: operation and status codes,
// controller/datapath command and status structs. No dependencies.
package rau_pkg;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd1;
  localparam logic [2:0] FN_MUL = 3'd2;
  localparam logic [2:0] FN_DIV = 3'd3;
  localparam logic [2:0] FN_INC = 3'd4;
  localparam logic [2:0] FN_DEC = 3'd5;
  localparam logic [2:0] FN_CMP = 3'd6;
  localparam logic [2:0] FN_RED = 3'd7;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZDEN = 2'd1;
  localparam logic [1:0] STAT_DIVZ = 2'd2;
  localparam logic [1:0] STAT_OVF  = 2'd3;

  localparam logic [1:0] MUL_P0 = 2'd0;
  localparam logic [1:0] MUL_P1 = 2'd1;
  localparam logic [1:0] MUL_P2 = 2'd2;

  localparam logic [6:0] DIV_STEPS = 7'd64;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       comb;
    logic       gcd_step;
    logic       div_init;
    logic       div_den;
    logic       div_step;
    logic       div_store_num;
    logic       div_store_den;
    logic       fin;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic gcd_done;
    logic div_done;
  } sts_t;

endpackage

// ===== src/rau_datapath.sv =====
// Datapath of the rational arithmetic unit: operand capture, shared multiplier,
// signed add, binary gcd, restoring divider and output registers. Uses rau_pkg.
module rau_datapath #(
  parameter int W = 32
) (
  input  logic               clk_i,
  input  rau_pkg::cmd_t      cmd_i,
  output rau_pkg::sts_t      sts_o,
  input  logic [2:0]         func_i,
  input  logic [31:0]        num_a_i,
  input  logic [31:0]        den_a_i,
  input  logic [31:0]        num_b_i,
  input  logic [31:0]        den_b_i,
  output logic signed [31:0] res_num_o,
  output logic [30:0]        res_den_o,
  output logic signed [1:0]  order_o,
  output logic [1:0]         status_o
);
  import rau_pkg::*;

  localparam int          SH  = 32 - W;
  localparam logic [63:0] LIM = 64'd1 << (W - 1);

  function automatic logic [32:0] split(logic [31:0] raw);
    logic signed [31:0] t;
    logic signed [31:0] x;
    t = raw << SH;
    x = t >>> SH;
    return {x[31], x[31] ? (32'd0 - $unsigned(x)) : $unsigned(x)};
  endfunction

  function automatic logic [64:0] sadd(logic [64:0] a, logic [64:0] b);
    logic [64:0] r;
    if (a[64] == b[64]) begin
      r = {a[64], a[63:0] + b[63:0]};
    end else if (a[63:0] >= b[63:0]) begin
      r = {a[64], a[63:0] - b[63:0]};
    end else begin
      r = {b[64], b[63:0] - a[63:0]};
    end
    if (r[63:0] == 64'd0) begin
      r[64] = 1'b0;
    end
    return r;
  endfunction

  logic [2:0]  func_q;
  logic        na_neg_q, nb_neg_q;
  logic [31:0] na_q, nb_q, da_q, db_q;
  logic [1:0]  stat_q;
  logic [63:0] p0_q, p1_q, p2_q;
  logic        p0_neg_q, p1_neg_q, p2_neg_q;
  logic        rn_neg_q;
  logic [63:0] rn_q, rd_q;
  logic [1:0]  ord_q;
  logic [63:0] ga_q, gb_q;
  logic [5:0]  gk_q;
  logic [63:0] dvsr_q, dq_q, rem_q;
  logic [6:0]  cnt_q;
  logic signed [31:0] res_num_q;
  logic [30:0] res_den_q;
  logic [1:0]  order_q, status_q;

  logic [32:0] sa, sda, sb, sdb;
  logic        binary;
  logic [1:0]  stat_d;

  always_comb begin
    sa     = split(num_a_i);
    sda    = split(den_a_i);
    sb     = split(num_b_i);
    sdb    = split(den_b_i);
    binary = (func_i <= FN_DIV) || (func_i == FN_CMP);
    if (sda[31:0] == 32'd0 || (binary && sdb[31:0] == 32'd0)) begin
      stat_d = STAT_ZDEN;
    end else if (func_i == FN_DIV && sb[31:0] == 32'd0) begin
      stat_d = STAT_DIVZ;
    end else begin
      stat_d = STAT_OK;
    end
  end

  logic [31:0] ma, mb;
  logic        msg;
  logic [63:0] prod;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_P0: begin
        ma  = na_q;
        mb  = (func_q == FN_MUL) ? nb_q : db_q;
        msg = na_neg_q ^ ((func_q == FN_MUL) & nb_neg_q);
      end
      MUL_P1: begin
        ma  = nb_q;
        mb  = da_q;
        msg = nb_neg_q;
      end
      default: begin
        ma  = da_q;
        mb  = (func_q == FN_DIV) ? nb_q : db_q;
        msg = (func_q == FN_DIV) & nb_neg_q;
      end
    endcase
    prod = 64'(ma) * 64'(mb);
  end

  logic        unary;
  logic [64:0] xo, yo, sum, rn_c, rd_c;
  logic [1:0]  ord_c;

  always_comb begin
    unary = (func_q == FN_INC) || (func_q == FN_DEC) || (func_q == FN_RED);
    xo = unary ? {na_neg_q, 32'd0, na_q} : {p0_neg_q, p0_q};
    yo = (func_q == FN_INC || func_q == FN_DEC) ? {1'b0, 32'd0, da_q} : {p1_neg_q, p1_q};
    if ((func_q == FN_SUB || func_q == FN_DEC || func_q == FN_CMP) && yo[63:0] != 64'd0) begin
      yo[64] = ~yo[64];
    end
    sum   = sadd(xo, yo);
    ord_c = 2'b00;
    case (func_q)
      FN_ADD, FN_SUB, FN_MUL, FN_DIV: rd_c = {p2_neg_q, p2_q};
      FN_CMP:  rd_c = {1'b0, 64'd1};
      default: rd_c = {1'b0, 32'd0, da_q};
    endcase
    case (func_q)
      FN_ADD, FN_SUB, FN_INC, FN_DEC: rn_c = sum;
      FN_CMP: begin
        rn_c = 65'd0;
        if (sum[63:0] != 64'd0) begin
          ord_c = sum[64] ? 2'b11 : 2'b01;
        end
      end
      default: rn_c = xo;
    endcase
    if (rd_c[64] && rn_c[63:0] != 64'd0) begin
      rn_c[64] = ~rn_c[64];
    end
  end

  logic [63:0] gval;
  logic [64:0] dtry;
  logic        dbit;

  always_comb begin
    gval = (ga_q | gb_q) << gk_q;
    dtry = {rem_q, dq_q[63]};
    dbit = dtry >= {1'b0, dvsr_q};
  end

  logic       ovf, bad;
  logic [1:0] stat_f;

  always_comb begin
    ovf = (rd_q > LIM - 64'd1) || (rn_q > (rn_neg_q ? LIM : LIM - 64'd1));
    bad = (stat_q != STAT_OK) || ovf;
    if (stat_q != STAT_OK) begin
      stat_f = stat_q;
    end else if (ovf) begin
      stat_f = STAT_OVF;
    end else begin
      stat_f = STAT_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= func_i;
      na_q     <= sa[31:0];
      nb_q     <= sb[31:0];
      da_q     <= sda[31:0];
      db_q     <= sdb[31:0];
      na_neg_q <= sa[32] ^ (sda[32] && sa[31:0] != 32'd0);
      nb_neg_q <= sb[32] ^ (sdb[32] && sb[31:0] != 32'd0);
      stat_q   <= stat_d;
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        MUL_P0: begin
          p0_q     <= prod;
          p0_neg_q <= msg && prod != 64'd0;
        end
        MUL_P1: begin
          p1_q     <= prod;
          p1_neg_q <= msg && prod != 64'd0;
        end
        default: begin
          p2_q     <= prod;
          p2_neg_q <= msg && prod != 64'd0;
        end
      endcase
    end
    if (cmd_i.comb) begin
      rn_neg_q <= rn_c[64];
      rn_q     <= rn_c[63:0];
      rd_q     <= rd_c[63:0];
      ga_q     <= rn_c[63:0];
      gb_q     <= rd_c[63:0];
      gk_q     <= 6'd0;
      ord_q    <= ord_c;
    end
    if (cmd_i.gcd_step) begin
      if (!ga_q[0] && !gb_q[0]) begin
        ga_q <= ga_q >> 1;
        gb_q <= gb_q >> 1;
        gk_q <= gk_q + 6'd1;
      end else if (!ga_q[0]) begin
        ga_q <= ga_q >> 1;
      end else if (!gb_q[0]) begin
        gb_q <= gb_q >> 1;
      end else if (ga_q >= gb_q) begin
        ga_q <= ga_q - gb_q;
      end else begin
        gb_q <= gb_q - ga_q;
      end
    end
    if (cmd_i.div_init) begin
      if (!cmd_i.div_den) begin
        dvsr_q <= gval;
      end
      dq_q  <= cmd_i.div_den ? rd_q : rn_q;
      rem_q <= 64'd0;
      cnt_q <= 7'd0;
    end else if (cmd_i.div_step) begin
      rem_q <= dbit ? 64'(dtry - {1'b0, dvsr_q}) : dtry[63:0];
      dq_q  <= {dq_q[62:0], dbit};
      cnt_q <= cnt_q + 7'd1;
    end
    if (cmd_i.div_store_num) begin
      rn_q <= dq_q;
    end
    if (cmd_i.div_store_den) begin
      rd_q <= dq_q;
    end
    if (cmd_i.fin) begin
      res_num_q <= bad ? 32'sd0 : $signed(rn_neg_q ? 32'd0 - rn_q[31:0] : rn_q[31:0]);
      res_den_q <= bad ? 31'd1 : rd_q[30:0];
      order_q   <= bad ? 2'b00 : ord_q;
      status_q  <= stat_f;
    end
  end

  assign sts_o.err      = stat_q != STAT_OK;
  assign sts_o.gcd_done = (ga_q == 64'd0) || (gb_q == 64'd0);
  assign sts_o.div_done = cnt_q == DIV_STEPS;

  assign res_num_o = res_num_q;
  assign res_den_o = res_den_q;
  assign order_o   = $signed(order_q);
  assign status_o  = status_q;

endmodule

// ===== src/rau_ctrl.sv =====
// Controller of the rational arithmetic unit: sequencing state machine and
// output valid. Uses rau_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rau_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rau_pkg::cmd_t cmd_o,
  input  rau_pkg::sts_t sts_i
);
  import rau_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL0 = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_MUL2 = 4'd3;
  localparam logic [3:0] S_COMB = 4'd4;
  localparam logic [3:0] S_GCD  = 4'd5;
  localparam logic [3:0] S_DIVN = 4'd6;
  localparam logic [3:0] S_DIVD = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free, in_xfer;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = state_q != S_IDLE;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL0;
        end
      end
      S_MUL0: begin
        if (sts_i.err) begin
          state_d = S_FIN;
        end else begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MUL_P0;
          state_d       = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_P1;
        state_d       = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_P2;
        state_d       = S_COMB;
      end
      S_COMB: begin
        cmd_o.comb = 1'b1;
        state_d    = S_GCD;
      end
      S_GCD: begin
        if (sts_i.gcd_done) begin
          cmd_o.div_init = 1'b1;
          state_d        = S_DIVN;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      S_DIVN: begin
        if (sts_i.div_done) begin
          cmd_o.div_store_num = 1'b1;
          cmd_o.div_init      = 1'b1;
          cmd_o.div_den       = 1'b1;
          state_d             = S_DIVD;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_DIVD: begin
        if (sts_i.div_done) begin
          cmd_o.div_store_den = 1'b1;
          state_d             = S_FIN;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.fin   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `RAU_ASSERT_NXT(a_xfer_starts, in_xfer, state_q == S_MUL0, "transfer did not start work")
  `RAU_ASSERT_IMP(a_fin_free, cmd_o.fin, out_free, "result overwrites pending output")
  `RAU_ASSERT_IMP(a_rose_after_fin, $rose(out_valid_q), $past(state_q) == S_FIN, "valid without finish")

endmodule

// ===== src/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: controller plus datapath.
// Depends on rau_pkg, rau_ctrl and rau_datapath.
//
// Usage: present func_i and the two fractions on the input channel with
// in_valid_i; a transfer happens when in_stall_o is low. One result item
// (res_num_o, res_den_o, order_o, status_o) comes out per input item on the
// output channel, transferred when out_valid_o is high and out_stall_i low.
// Each item runs through three multiplier states, a binary gcd over 64-bit
// magnitudes, then two 64-step restoring divisions by the gcd; the length
// of the gcd loop depends on the operands. Items with a zero denominator or
// a division by zero skip the arithmetic and go from the first multiplier
// state straight to the finish state. One item is in flight at a time; the
// next one is taken as soon as the result sits in the output register, even
// while it is stalled. If the output is still stalled when a new result is
// ready, the work holds until the output register frees. Reset clears the
// sequencer and the output valid; no state carries between items.
module rational_arithmetic_unit #(
  parameter int WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] num_a_i,
  input  logic signed [31:0] den_a_i,
  input  logic signed [31:0] num_b_i,
  input  logic signed [31:0] den_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] res_num_o,
  output logic [30:0]        res_den_o,
  output logic signed [1:0]  order_o,
  output logic [1:0]         status_o
);
  import rau_pkg::*;

  localparam int W = (WIDTH < 8) ? 8 : ((WIDTH > 32) ? 32 : WIDTH);

  cmd_t cmd;
  sts_t sts;

  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rau_datapath #(.W(W)) u_dp (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .func_i    (func_i),
    .num_a_i   ($unsigned(num_a_i)),
    .den_a_i   ($unsigned(den_a_i)),
    .num_b_i   ($unsigned(num_b_i)),
    .den_b_i   ($unsigned(den_b_i)),
    .res_num_o (res_num_o),
    .res_den_o (res_den_o),
    .order_o   (order_o),
    .status_o  (status_o)
  );

endmodule
